// File: sv/bayer_bilinear_demosaic_unit_assert.svh
// Assertion macros for the bilinear demosaic unit.
`ifndef BAYER_BILINEAR_DEMOSAIC_UNIT_ASSERT_SVH
`define BAYER_BILINEAR_DEMOSAIC_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define BBD_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define BBD_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: sv/bbd_pkg.sv
// Package for the bilinear demosaic unit: constants, types, helpers.
package bbd_pkg;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int PIXEL_BITS_DEF = 16;
  localparam int LW_BITS = 12;
  localparam int FH_BITS = 13;
  localparam int CFG_ADDR_BITS = 1;
  localparam int CFG_DATA_BITS = 13;
  localparam logic [CFG_ADDR_BITS-1:0] REG_LINE_WIDTH   = 1'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_FRAME_HEIGHT = 1'd1;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_CALC} bbd_state_t;

  typedef struct packed {
    logic restart;   // clear counters and window
    logic rd;        // issue line store read
    logic step;      // shift window, write stores, advance position
    logic load_out;  // capture result
  } bbd_cmd_t;

  typedef struct packed {
    logic emit;      // current item produces a result
  } bbd_sts_t;

  // divide a small sum by 1..4 (truncating); 3 uses a reciprocal
  function automatic logic [17:0] div_small(input logic [17:0] s, input logic [2:0] n);
    logic [37:0] p;
    begin
      p = 38'(s) * 38'd349526;
      case (n)
        3'd1: div_small = s;
        3'd2: div_small = s >> 1;
        3'd3: div_small = 18'(p >> 20);
        3'd4: div_small = s >> 2;
        default: div_small = '0;
      endcase
    end
  endfunction
endpackage

// File: sv/bbd_stream_if.sv
// Valid/ready channel interface with generic payload.
interface bbd_stream_if #(parameter int W = 1) (input logic clk);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/bbd_ctrl.sv
// Controller state machine for the demosaic unit.
module bbd_ctrl import bbd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic in_fire,
  input  logic out_fire,
  input  bbd_sts_t sts,
  output logic in_ready,
  output logic out_valid,
  output bbd_cmd_t cmd
);
  `include "bayer_bilinear_demosaic_unit_assert.svh"
  bbd_state_t state_r, state_nxt;
  logic ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ov_nxt = ov_r;
    cmd = '0;
    cmd.restart = cfg_we;
    in_ready = 1'b0;
    if (out_fire) ov_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = !cfg_we;
        if (in_fire) begin
          cmd.rd = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_CALC;
      ST_CALC: begin
        // hold here while the previous result still sits in the output register
        if (!sts.emit) begin
          cmd.step = 1'b1;
          state_nxt = ST_IDLE;
        end else if (!ov_r || out_fire) begin
          cmd.step = 1'b1;
          cmd.load_out = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = ov_r;

  `BBD_ASSERT_IMP(a_rdy_idle, clk, rst_n, in_ready, state_r == ST_IDLE)
  `BBD_ASSERT_NEXT(a_fire_read, clk, rst_n, in_fire, state_r == ST_READ)
  `BBD_ASSERT_IMP(a_load_free, clk, rst_n, cmd.load_out, !ov_r || out_fire)
endmodule

// File: sv/bbd_datapath.sv
// Datapath: line stores, 3x3 window, position counters, interpolation.
module bbd_datapath import bbd_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic in_fire,
  input  logic [15:0] in_pixel,
  input  logic in_drain,
  input  bbd_cmd_t cmd,
  output bbd_sts_t sts,
  output logic [15:0] red,
  output logic [15:0] green,
  output logic [15:0] blue,
  output logic frame_end
);
  `include "bayer_bilinear_demosaic_unit_assert.svh"
  localparam int CB = $clog2(MAX_WIDTH);
  localparam int XB = CB + 1;
  localparam int RB = $clog2(MAX_HEIGHT) + 2;

  logic [15:0] upper_mem [MAX_WIDTH];
  logic [15:0] mid_mem [MAX_WIDTH];
  logic [15:0] u_rd_r, m_rd_r, v_r;
  logic [15:0] win_r [3][3];
  logic [XB-1:0] col_r, w_r;
  logic [RB-1:0] row_r, h_r;
  logic [11:0] drain_cnt_r;

  // clamped register values
  logic [LW_BITS-1:0] lw_in;
  logic [FH_BITS-1:0] fh_in;
  logic [XB-1:0] w_cl;
  logic [RB-1:0] h_cl;
  always_comb begin
    lw_in = cfg_wdata[LW_BITS-1:0];
    fh_in = cfg_wdata[FH_BITS-1:0];
    if (32'(lw_in) < 2) w_cl = XB'(2);
    else if (32'(lw_in) > MAX_WIDTH) w_cl = XB'(MAX_WIDTH);
    else w_cl = XB'(lw_in);
    if (32'(fh_in) < 2) h_cl = RB'(2);
    else if (32'(fh_in) > MAX_HEIGHT) h_cl = RB'(MAX_HEIGHT);
    else h_cl = RB'(fh_in);
  end

  logic [CB-1:0] cidx;
  assign cidx = col_r[CB-1:0];

  // line store read; write on step
  always_ff @(posedge clk) begin
    if (in_fire) begin
      v_r <= (in_drain || row_r >= h_r) ? 16'd0
           : 16'(in_pixel[PIXEL_BITS-1:0]);
    end
    if (cmd.rd) begin
      u_rd_r <= upper_mem[cidx];
      m_rd_r <= mid_mem[cidx];
    end
    if (cmd.step) begin
      upper_mem[cidx] <= m_rd_r;
      mid_mem[cidx] <= v_r;
    end
  end

  // window after this step
  logic [15:0] nw [3][3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nw[r][0] = win_r[r][1];
      nw[r][1] = win_r[r][2];
    end
    nw[0][2] = u_rd_r;
    nw[1][2] = m_rd_r;
    nw[2][2] = v_r;
  end

  // output site position
  logic emit, fend;
  logic [XB-1:0] cx;
  logic [RB-1:0] cy;
  always_comb begin
    emit = (row_r >= RB'(2)) || (row_r == RB'(1) && col_r >= XB'(1));
    if (col_r >= XB'(1)) begin
      cx = col_r - XB'(1);
      cy = row_r - RB'(1);
    end else begin
      cx = w_r - XB'(1);
      cy = row_r - RB'(2);
    end
    fend = emit && (cy + RB'(1) == h_r) && (cx + XB'(1) == w_r);
  end
  assign sts.emit = emit;

  // interpolation
  logic lv, rv, uv, dv;
  logic [17:0] hs, vs, ds;
  logic [2:0] hn, vn, dn;
  logic [17:0] g_x, d_x, h_m, v_m;
  logic [15:0] own;
  always_comb begin
    lv = cx != '0;
    rv = cx + XB'(1) < w_r;
    uv = cy != '0;
    dv = cy + RB'(1) < h_r;
    hs = '0; vs = '0; ds = '0; hn = '0; vn = '0; dn = '0;
    if (lv) begin hs = hs + 18'(nw[1][0]); hn = hn + 3'd1; end
    if (rv) begin hs = hs + 18'(nw[1][2]); hn = hn + 3'd1; end
    if (uv) begin vs = vs + 18'(nw[0][1]); vn = vn + 3'd1; end
    if (dv) begin vs = vs + 18'(nw[2][1]); vn = vn + 3'd1; end
    if (uv && lv) begin ds = ds + 18'(nw[0][0]); dn = dn + 3'd1; end
    if (uv && rv) begin ds = ds + 18'(nw[0][2]); dn = dn + 3'd1; end
    if (dv && lv) begin ds = ds + 18'(nw[2][0]); dn = dn + 3'd1; end
    if (dv && rv) begin ds = ds + 18'(nw[2][2]); dn = dn + 3'd1; end
    own = nw[1][1];
    g_x = div_small(hs + vs, hn + vn);
    d_x = div_small(ds, dn);
    h_m = div_small(hs, hn);
    v_m = div_small(vs, vn);
  end

  logic [15:0] r_c, g_c, b_c;
  always_comb begin
    case ({cy[0], cx[0]})
      2'b11: begin r_c = own; g_c = g_x[15:0]; b_c = d_x[15:0]; end
      2'b00: begin b_c = own; g_c = g_x[15:0]; r_c = d_x[15:0]; end
      2'b01: begin g_c = own; b_c = h_m[15:0]; r_c = v_m[15:0]; end
      default: begin g_c = own; r_c = h_m[15:0]; b_c = v_m[15:0]; end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= XB'(1920 > MAX_WIDTH ? MAX_WIDTH : 1920);
      h_r <= RB'(1080 > MAX_HEIGHT ? MAX_HEIGHT : 1080);
      col_r <= '0;
      row_r <= '0;
      drain_cnt_r <= '0;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) win_r[r][c] <= '0;
    end else if (cmd.restart) begin
      if (cfg_addr == REG_LINE_WIDTH) w_r <= w_cl;
      if (cfg_addr == REG_FRAME_HEIGHT) h_r <= h_cl;
      col_r <= '0;
      row_r <= '0;
      drain_cnt_r <= '0;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) win_r[r][c] <= '0;
    end else if (cmd.step) begin
      win_r <= nw;
      if (fend) begin
        col_r <= '0;
        row_r <= '0;
        drain_cnt_r <= '0;
      end else begin
        if (row_r >= h_r) drain_cnt_r <= drain_cnt_r + 12'd1;
        if (col_r + XB'(1) >= w_r) begin
          col_r <= '0;
          row_r <= row_r + RB'(1);
        end else begin
          col_r <= col_r + XB'(1);
        end
      end
    end
  end

  // result register
  logic fend_r;
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      fend_r <= fend;
      red <= r_c;
      green <= g_c;
      blue <= b_c;
    end
  end
  assign frame_end = fend_r;

  `BBD_ASSERT_IMP(a_col_range, clk, rst_n, 1'b1, col_r < w_r)
  `BBD_ASSERT_IMP(a_drain_in_flush, clk, rst_n, drain_cnt_r != '0, row_r >= h_r)
  `BBD_ASSERT_NEXT(a_fend_wrap, clk, rst_n, cmd.step && fend && !cmd.restart,
    col_r == '0 && row_r == '0)
endmodule

// File: sv/bayer_bilinear_demosaic_unit.sv
// Bilinear BGGR demosaic unit. Pixel beats are taken one at a time: a new beat
// is not accepted until the last has passed accept, line store read and
// interpolate with output load (the registered line store read needs its own
// state), and any stall in the interpolate state while the previous result is
// still waiting. Results lag inputs by one line plus one pixel; line_width+1
// drain beats flush a frame. Register writes restart the frame.
module bayer_bilinear_demosaic_unit import bbd_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic in_valid,
  output logic in_ready,
  input  logic [15:0] in_pixel_value,
  input  logic in_drain,
  output logic out_valid,
  input  logic out_ready,
  output logic [15:0] out_red,
  output logic [15:0] out_green,
  output logic [15:0] out_blue,
  output logic out_frame_end
);
  bbd_stream_if #(.W(17)) in_ch (clk);
  bbd_stream_if #(.W(49)) out_ch (clk);
  bbd_cmd_t cmd;
  bbd_sts_t sts;
  logic in_fire, out_fire;

  assign in_ch.valid = in_valid;
  assign in_ch.data = {in_drain, in_pixel_value};
  assign in_ready = in_ch.ready;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_ch.ready = out_ready;
  assign out_valid = out_ch.valid;
  assign {out_frame_end, out_red, out_green, out_blue} = out_ch.data;
  assign out_fire = out_ch.valid && out_ch.ready;

  bbd_ctrl u_ctrl (
    .clk, .rst_n, .cfg_we, .in_fire, .out_fire, .sts,
    .in_ready(in_ch.ready), .out_valid(out_ch.valid), .cmd
  );

  bbd_datapath #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .PIXEL_BITS(PIXEL_BITS)
  ) u_dp (
    .clk, .rst_n, .cfg_addr, .cfg_wdata, .in_fire,
    .in_pixel(in_ch.data[15:0]), .in_drain(in_ch.data[16]), .cmd, .sts,
    .red(out_ch.data[47:32]), .green(out_ch.data[31:16]),
    .blue(out_ch.data[15:0]), .frame_end(out_ch.data[48])
  );
endmodule

// File: tb/bbd_checker.sv
// Demosaic checker: watches the channels, predicts RGB per pixel beat and compares.
`timescale 1ns / 1ps
module bbd_checker import bbd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic in_valid,
  input  logic in_ready,
  input  logic [16:0] in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  logic [48:0] out_data,
  output int fail_count,
  output int pending,
  output int result_count
);
  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        frame_end;
  } rgb_px_t;

  logic [15:0] upper_line[MAX_WIDTH_DEF];
  logic [15:0] middle_line[MAX_WIDTH_DEF];
  logic [15:0] win[3][3];
  int col, row, line_w, frame_h;
  rgb_px_t expected_px[$];

  initial begin
    fail_count = 0;
    result_count = 0;
    for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
  end

  assign pending = expected_px.size();

  function automatic int clamp_to(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic logic [15:0] mean_of(int s, int n);
    return (n != 0) ? 16'(s / n) : 16'd0;
  endfunction

  task automatic restart_frame();
    col = 0;
    row = 0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) win[r][c] = '0;
  endtask

  task automatic report(input string field, input logic [15:0] got, input logic [15:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
    fail_count++;
  endtask

  task automatic demosaic_step(input logic [15:0] pix, input logic drn);
    logic [15:0] v, u, m, own;
    int cx, cy, hs, hn, vs, vn, ds, dn;
    bit lv, rv, uv, dv, emit;
    rgb_px_t px;
    v = (drn || row >= frame_h) ? 16'd0 : pix;
    u = upper_line[col];
    m = middle_line[col];
    upper_line[col] = m;
    middle_line[col] = v;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = u;
    win[1][2] = m;
    win[2][2] = v;
    emit = (row >= 2) || (row == 1 && col >= 1);
    if (col >= 1) begin
      cx = col - 1;
      cy = row - 1;
    end else begin
      cx = line_w - 1;
      cy = row - 2;
    end
    px = '0;
    if (emit) begin
      lv = cx > 0; rv = cx + 1 < line_w; uv = cy > 0; dv = cy + 1 < frame_h;
      own = win[1][1];
      hs = 0; hn = 0; vs = 0; vn = 0; ds = 0; dn = 0;
      if (lv) begin hs += win[1][0]; hn++; end
      if (rv) begin hs += win[1][2]; hn++; end
      if (uv) begin vs += win[0][1]; vn++; end
      if (dv) begin vs += win[2][1]; vn++; end
      if (uv && lv) begin ds += win[0][0]; dn++; end
      if (uv && rv) begin ds += win[0][2]; dn++; end
      if (dv && lv) begin ds += win[2][0]; dn++; end
      if (dv && rv) begin ds += win[2][2]; dn++; end
      if (cy[0] && cx[0]) begin
        px.red = own;
        px.green = mean_of(hs + vs, hn + vn);
        px.blue = mean_of(ds, dn);
      end else if (!cy[0] && !cx[0]) begin
        px.blue = own;
        px.green = mean_of(hs + vs, hn + vn);
        px.red = mean_of(ds, dn);
      end else if (!cy[0]) begin
        // green on a blue row: horizontal pair is blue
        px.green = own;
        px.blue = mean_of(hs, hn);
        px.red = mean_of(vs, vn);
      end else begin
        px.green = own;
        px.red = mean_of(hs, hn);
        px.blue = mean_of(vs, vn);
      end
      px.frame_end = (cy + 1 == frame_h) && (cx + 1 == line_w);
      expected_px.push_back(px);
    end
    if (px.frame_end) begin
      col = 0;
      row = 0;
    end else begin
      col++;
      if (col >= line_w) begin
        col = 0;
        row++;
      end
    end
  endtask

  always @(posedge clk) begin
    rgb_px_t got, want;
    if (!rst_n) begin
      line_w = 1920;
      frame_h = 1080;
      restart_frame();
      expected_px.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_LINE_WIDTH) line_w = clamp_to(int'(cfg_wdata[11:0]), 2, MAX_WIDTH_DEF);
        else frame_h = clamp_to(int'(cfg_wdata), 2, MAX_HEIGHT_DEF);
        restart_frame();
      end
      if (in_valid && in_ready) demosaic_step(in_data[15:0], in_data[16]);
      if (out_valid && out_ready) begin
        got = out_data;
        result_count++;
        if (expected_px.size() == 0) begin
          $display("MISMATCH unexpected result %0h at %0t", out_data, $realtime);
          fail_count++;
        end else begin
          want = expected_px.pop_front();
          if (got.red !== want.red) report("red", got.red, want.red);
          if (got.green !== want.green) report("green", got.green, want.green);
          if (got.blue !== want.blue) report("blue", got.blue, want.blue);
          if (got.frame_end !== want.frame_end)
            report("frame_end", 16'(got.frame_end), 16'(want.frame_end));
        end
      end
    end
  end
endmodule

// File: tb/tb_top.sv
// Top of the demosaic testbench: clock, reset, stimulus, receiver, verdict.
`timescale 1ns / 1ps
module tb_top;
  import bbd_pkg::*;

  localparam int IDLE_WAIT = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  logic clk, rst_n;
  logic cfg_we;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;
  logic [15:0] red, green, blue;
  logic frame_end;
  int fail_count, pending, result_count;
  int beats, frames, cur_w, cur_h, idle_cycles;
  bit hold_req, calm_rx, calm_tx;

  bbd_stream_if #(17) in_ch (clk);
  bbd_stream_if #(49) out_ch (clk);

  assign out_ch.data = {red, green, blue, frame_end};

  bayer_bilinear_demosaic_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_pixel_value(in_ch.data[15:0]), .in_drain(in_ch.data[16]),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_red(red), .out_green(green), .out_blue(blue), .out_frame_end(frame_end)
  );

  bbd_checker chk (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // stall length: mostly short, now and then long
  function automatic int pick_gap(bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic int clamp_to(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  task automatic send_beat(input logic [15:0] pix, input logic drn);
    int gap;
    gap = pick_gap(calm_tx);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= {drn, pix};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats++;
  endtask

  // wait until every expected pixel is out, then let the pipeline go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_LINE_WIDTH) cur_w = clamp_to(int'(val[11:0]), 2, MAX_WIDTH_DEF);
    else cur_h = clamp_to(int'(val), 2, MAX_HEIGHT_DEF);
  endtask

  // cut > 0 stops the frame early after that many beats
  task automatic send_frame(input int cut);
    int n;
    n = cur_w * cur_h;
    if (cut > 0) begin
      for (int i = 0; i < cut && i < n; i++) send_beat(pick_pixel(), $urandom_range(0, 19) == 0);
      return;
    end
    for (int i = 0; i < n; i++) send_beat(pick_pixel(), $urandom_range(0, 19) == 0);
    // flush beats: data is ignored whatever the drain bit
    for (int i = 0; i <= cur_w; i++) send_beat(pick_pixel(), 1'($urandom_range(0, 1)));
    frames++;
  endtask

  // receiver
  initial begin
    int stall_left, mode_left;
    stall_left = 0;
    mode_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        calm_rx = $urandom_range(0, 3) == 0;
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (calm_rx || $urandom_range(0, 9) < 7) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no beat for %0d cycles", idle_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] ramp[16];
    beats = 0;
    frames = 0;
    cur_w = 1920;
    cur_h = 1080;
    hold_req = 1'b0;
    calm_tx = 1'b0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= REG_LINE_WIDTH;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed 4x4 frame: full-scale checkerboard, a drain in-frame, dirty flush data;
    // the receiver holds off meanwhile so the block backs up
    write_reg(REG_LINE_WIDTH, 13'd4);
    write_reg(REG_FRAME_HEIGHT, 13'd4);
    for (int i = 0; i < 16; i++) ramp[i] = ((i + i / 4) % 2 == 0) ? 16'hFFFF : 16'h0000;
    ramp[5] = 16'h1234;
    ramp[10] = 16'hABCD;
    hold_req = 1'b1;
    for (int i = 0; i < 16; i++) send_beat(ramp[i], i == 6);
    for (int i = 0; i < 5; i++) send_beat(16'hFFFF, 1'b0);
    frames++;
    settle();

    // out-of-range low register values clamp to the 2x2 minimum
    write_reg(REG_LINE_WIDTH, 13'd0);
    write_reg(REG_FRAME_HEIGHT, 13'd1);
    send_frame(0);
    settle();

    while (beats < 440) begin
      case ($urandom_range(0, 5))
        0: write_reg(REG_LINE_WIDTH, 13'h1000 | 13'($urandom_range(2, 7)));
        1: write_reg(REG_LINE_WIDTH, 13'd1);
        default: write_reg(REG_LINE_WIDTH, 13'($urandom_range(2, 9)));
      endcase
      write_reg(REG_FRAME_HEIGHT, ($urandom_range(0, 7) == 0) ? 13'd0 : 13'($urandom_range(2, 7)));
      calm_tx = $urandom_range(0, 3) == 0;
      if ($urandom_range(0, 7) == 0) hold_req = 1'b1;
      for (int f = $urandom_range(1, 3); f > 0; f--) begin
        if ($urandom_range(0, 9) == 0) begin
          send_frame($urandom_range(1, cur_w * cur_h));
          break;
        end
        send_frame(0);
        if ($urandom_range(0, 3) == 0) settle();
      end
      settle();
    end
    calm_tx = 1'b0;

    // widest line store and tallest frame, partial frames only
    write_reg(REG_LINE_WIDTH, 13'd4095);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    send_frame(40);
    settle();
    write_reg(REG_FRAME_HEIGHT, 13'd8191);
    write_reg(REG_LINE_WIDTH, 13'd2);
    send_frame(30);
    settle();

    $display("Covered %0d pixel beats over %0d full frames, %0d RGB results checked",
             beats, frames, result_count);
    $display("Widths 2..2048, heights 2..4096, register clamping, in-frame drain, output stalls");
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+sv
sv/bbd_pkg.sv
sv/bbd_stream_if.sv
sv/bbd_ctrl.sv
sv/bbd_datapath.sv
sv/bayer_bilinear_demosaic_unit.sv
tb/bbd_checker.sv
tb/tb_top.sv
